// ===== rtl/core/cma_pkg.sv =====
`timescale 1ns / 1ps
package cma_pkg;

  // width and reset value of the half width register
  localparam int unsigned HW_BITS = 4;
  localparam logic [HW_BITS-1:0] HW_RESET = 4'd7;

  // per-cycle control of one delay cell
  typedef struct packed {
    logic shift;   // take the left neighbor (new sample enters cell 0)
    logic rotate;  // take the right neighbor, last cell wraps to cell 0
  } cma_cell_ctl_t;

endpackage

// ===== rtl/core/cma_ifs.sv =====
`timescale 1ns / 1ps
interface cma_sample_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_x;
  logic signed [SAMPLE_BITS-1:0] sample_y;
  logic signed [SAMPLE_BITS-1:0] sample_z;
  logic                          seq_end;

  modport source (output valid, sample_x, sample_y, sample_z, seq_end, input ready);
  modport sink (input valid, sample_x, sample_y, sample_z, seq_end, output ready);
endinterface

interface cma_avg_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] avg_x;
  logic signed [SAMPLE_BITS-1:0] avg_y;
  logic signed [SAMPLE_BITS-1:0] avg_z;
  logic                          final_out;

  modport source (output valid, avg_x, avg_y, avg_z, final_out, input ready);
  modport sink (input valid, avg_x, avg_y, avg_z, final_out, output ready);
endinterface

interface cma_cfg_if import cma_pkg::*;;
  logic               valid;
  logic               ready;
  logic [HW_BITS-1:0] half_width;

  modport source (output valid, half_width, input ready);
  modport sink (input valid, half_width, output ready);
endinterface

// ===== rtl/core/cma_cell.sv =====
`timescale 1ns / 1ps
module cma_cell import cma_pkg::*; #(
  parameter int WIDTH = 48
) (
  input  logic             clk,
  input  cma_cell_ctl_t    ctl,
  input  logic [WIDTH-1:0] left,
  input  logic [WIDTH-1:0] right,
  output logic [WIDTH-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= left;
    end else if (ctl.rotate) begin
      q <= right;
    end
  end

endmodule

// ===== rtl/core/cma_div.sv =====
`timescale 1ns / 1ps
module cma_div import cma_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_BITS    = 21,
  parameter int CNT_BITS    = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [SUM_BITS-1:0] sum,
  input  logic [HW_BITS-1:0]     half,
  input  logic [CNT_BITS-1:0]    cnt,
  output logic                   done,
  output logic [SAMPLE_BITS-1:0] quot
);

  localparam int ITER_BITS = $clog2(SUM_BITS + 1);

  logic [ITER_BITS-1:0] iter;
  logic [SUM_BITS-1:0]  work;
  logic [CNT_BITS-1:0]  rem;
  logic                 neg;

  logic [SUM_BITS-1:0]  mag;
  logic [SUM_BITS-1:0]  load_val;
  logic [CNT_BITS:0]    trial;
  logic [CNT_BITS:0]    diff;
  logic                 fits;
  logic [SUM_BITS-1:0]  neg_work;

  // magnitude plus half the divisor gives round half away from zero
  always_comb begin
    mag      = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    load_val = mag + SUM_BITS'(half);
    trial    = {rem, work[SUM_BITS-1]};
    diff     = trial - {1'b0, cnt};
    fits     = trial >= {1'b0, cnt};
    neg_work = -work;
    quot     = neg ? SAMPLE_BITS'(neg_work) : SAMPLE_BITS'(work);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (iter == ITER_BITS'(1));
      if (start) begin
        iter <= ITER_BITS'(SUM_BITS);
      end else if (iter != '0) begin
        iter <= iter - 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      work <= load_val;
      rem  <= '0;
      neg  <= sum[SUM_BITS-1];
    end else if (iter != '0) begin
      work <= {work[SUM_BITS-2:0], fits};
      rem  <= fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/centered_moving_average_vec3_core.sv =====
`timescale 1ns / 1ps
// centered moving average of three-axis samples
// samp: sample requests (x, y, z, seq_end); avg: averaged results (x, y, z,
//   final_out); cfg: half width writes, applied only between sequences
// each sample is averaged over the samples within J positions on both sides,
//   J = min(half_width, samples before it, samples after it in the sequence)
// the result for a sample leaves once half_width later samples have arrived;
//   the request with seq_end set flushes every owed result, the last marked
// one request at a time: each result takes one full rotation of the delay
//   cells to sum, then a bit-serial divide; no new sample is taken until
//   every result that the request gives has moved to the output register
// the next sample is taken while a finished result still waits in the output
//   register; a stalled receiver only holds up the next result
// reset clears all control state and sets half_width to 7; the delay cells
//   need no clearing since only samples of the current sequence are summed
module centered_moving_average_vec3_core import cma_pkg::*; #(
  parameter int MAX_HALF_WIDTH = 15,
  parameter int SAMPLE_BITS    = 16
) (
  input logic        clk,
  input logic        rst,
  cma_sample_if.sink samp,
  cma_avg_if.source  avg,
  cma_cfg_if.sink    cfg
);

  localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH + 1;
  localparam int POS_BITS  = $clog2(WIN_DEPTH);
  localparam int CNT_BITS  = $clog2(WIN_DEPTH + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
  localparam int CELL_BITS = 3 * SAMPLE_BITS;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state;

  // configuration and sequence bookkeeping
  logic [HW_BITS-1:0] half_width;
  logic [HW_BITS-1:0] seen;      // samples of this sequence, saturating
  logic [HW_BITS-1:0] given;     // results of this sequence, saturating
  logic [HW_BITS-1:0] d;         // distance of the sample being averaged
  logic               flush;
  logic [HW_BITS-1:0] j;         // half width of the current window
  logic [POS_BITS-1:0] lo;
  logic [POS_BITS-1:0] hi;
  logic [POS_BITS-1:0] pos;      // offset now sitting in cell 0

  logic signed [SUM_BITS-1:0] acc [3];
  logic                       div_start;
  logic [2:0]                 div_done;
  logic [SAMPLE_BITS-1:0]     div_q [3];

  // output register
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_x;
  logic [SAMPLE_BITS-1:0] out_y;
  logic [SAMPLE_BITS-1:0] out_z;
  logic                   out_final;

  logic [HW_BITS-1:0] h;
  logic [HW_BITS-1:0] pend;
  logic [HW_BITS-1:0] j_calc;
  logic               samp_take;
  logic               out_load;
  logic [CNT_BITS-1:0] cnt;

  cma_cell_ctl_t       cell_ctl;
  logic [CELL_BITS-1:0] new_sample;
  logic [CELL_BITS-1:0] cell_q [WIN_DEPTH];

  // effective half width saturates at the chain's reach
  always_comb begin
    if (32'(half_width) > MAX_HALF_WIDTH) begin
      h = HW_BITS'(MAX_HALF_WIDTH);
    end else begin
      h = half_width;
    end
    pend   = (seen < h) ? seen : h;
    j_calc = (given < h) ? given : h;
    if (d < j_calc) begin
      j_calc = d;
    end
    cnt = CNT_BITS'({j, 1'b1});
  end

  assign samp.ready = (state == ST_IDLE);
  assign samp_take  = samp.valid && samp.ready;
  assign cfg.ready  = 1'b1;
  assign out_load   = (state == ST_OUT) && (!out_valid || avg.ready);

  assign cell_ctl.shift  = samp_take;
  assign cell_ctl.rotate = (state == ST_SUM);
  assign new_sample      = {samp.sample_z, samp.sample_y, samp.sample_x};

  // delay line: cell k holds the sample k positions behind the newest;
  // while summing the row rotates so every cell passes through cell 0
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    logic [CELL_BITS-1:0] left;
    logic [CELL_BITS-1:0] right;
    if (k == 0) begin : g_first
      assign left = new_sample;
    end else begin : g_next
      assign left = cell_q[k-1];
    end
    if (k == WIN_DEPTH - 1) begin : g_wrap
      assign right = cell_q[0];
    end else begin : g_mid
      assign right = cell_q[k+1];
    end
    cma_cell #(
      .WIDTH (CELL_BITS)
    ) u_cell (
      .clk   (clk),
      .ctl   (cell_ctl),
      .left  (left),
      .right (right),
      .q     (cell_q[k])
    );
  end

  // one divider lane per axis, run in lockstep
  for (genvar c = 0; c < 3; c++) begin : g_lane
    cma_div #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS),
      .CNT_BITS    (CNT_BITS)
    ) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .sum   (acc[c]),
      .half  (j),
      .cnt   (cnt),
      .done  (div_done[c]),
      .quot  (div_q[c])
    );
  end

  // window sums: add cell 0 when its offset lies in [lo, hi]
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      for (int c = 0; c < 3; c++) begin
        acc[c] <= '0;
      end
    end else if (state == ST_SUM && pos >= lo && pos <= hi) begin
      for (int c = 0; c < 3; c++) begin
        acc[c] <= acc[c] +
                  SUM_BITS'($signed(cell_q[0][c*SAMPLE_BITS +: SAMPLE_BITS]));
      end
    end
  end

  // window bounds, fixed for one result
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      j  <= j_calc;
      lo <= POS_BITS'(d - j_calc);
      hi <= POS_BITS'({1'b0, d} + {1'b0, j_calc});
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x     <= div_q[0];
      out_y     <= div_q[1];
      out_z     <= div_q[2];
      out_final <= flush && (d == '0);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      half_width <= HW_RESET;
      seen       <= '0;
      given      <= '0;
      d          <= '0;
      flush      <= 1'b0;
      pos        <= '0;
      div_start  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // divider kicks off right after the last summing cycle
      div_start <= (state == ST_SUM) && (pos == POS_BITS'(WIN_DEPTH - 1));

      // half width only changes between sequences
      if (cfg.valid && seen == '0) begin
        half_width <= cfg.half_width;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (avg.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (samp_take) begin
            if (seen != '1) begin
              seen <= seen + 1'b1;
            end
            if (samp.seq_end) begin
              d     <= pend;
              flush <= 1'b1;
              state <= ST_PREP;
            end else if (pend == h) begin
              d     <= h;
              flush <= 1'b0;
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          pos   <= '0;
          state <= ST_SUM;
        end
        ST_SUM: begin
          pos <= pos + 1'b1;
          if (pos == POS_BITS'(WIN_DEPTH - 1)) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (&div_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (flush && d == '0) begin
              // sequence done, counters restart for the next one
              given <= '0;
            end else if (given != '1) begin
              given <= given + 1'b1;
            end
            if (!flush || d == '0) begin
              state <= ST_IDLE;
              if (flush) begin
                seen  <= '0;
                flush <= 1'b0;
              end
            end else begin
              d     <= d - 1'b1;
              state <= ST_PREP;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign avg.valid     = out_valid;
  assign avg.avg_x     = out_x;
  assign avg.avg_y     = out_y;
  assign avg.avg_z     = out_z;
  assign avg.final_out = out_final;

endmodule

// ===== tb/sv/tb_centered_moving_average_vec3_core.sv =====
`timescale 1ns / 1ps
module tb_centered_moving_average_vec3_core;
  import cma_pkg::*;

  localparam int SAMPLE_W        = 16;
  localparam int MAX_HW          = 15;
  localparam int WIN_DEPTH       = 2 * MAX_HW + 1;
  localparam int CNT_SAT         = 63;
  // pad after going idle, long enough to cover any work still in flight
  localparam int LATENCY_PAD     = 80;
  localparam int HOLD_CYCLES     = 600;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int ITEMS_PER_PHASE = 22;
  localparam int NUM_PHASES      = 8;
  localparam int RANDOM_HW       = -1;

  // idling per phase: none, sender, receiver, both
  localparam int SEND_IDLE[4]  = '{0, 78, 0, 35};
  localparam int RECV_STALL[4] = '{0, 0, 78, 35};
  localparam int PHASE_HW[NUM_PHASES] = '{1, 15, 0, RANDOM_HW, 15, RANDOM_HW, 2, RANDOM_HW};

  typedef struct {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
    logic                last;
    bit                  wait_drain;  // hold this request back until all averages are in
  } samp_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    logic                       fin;
  } avg_res_t;

  logic clk;
  logic rst;

  cma_sample_if #(.SAMPLE_BITS(SAMPLE_W)) samp_if ();
  cma_avg_if #(.SAMPLE_BITS(SAMPLE_W)) avg_if ();
  cma_cfg_if cfg_if ();

  centered_moving_average_vec3_core #(
    .MAX_HALF_WIDTH(MAX_HW),
    .SAMPLE_BITS   (SAMPLE_W)
  ) uut (
    .clk (clk),
    .rst (rst),
    .samp(samp_if),
    .avg (avg_if),
    .cfg (cfg_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // sample requests waiting to be offered, averages still owed by the block
  samp_req_t sample_backlog[$];
  avg_res_t  owed_avgs[$];
  samp_req_t next_req;
  avg_res_t  want_avg;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int hold_seen;
  int stall_left;
  int idle_cycles;
  int mismatches     = 0;
  bit drained        = 1'b1;

  // shadow of the block: half width, delay line and sequence counters
  logic [HW_BITS-1:0]         hw_reg;
  logic signed [SAMPLE_W-1:0] win[WIN_DEPTH][3];
  int unsigned                wr_slot;
  int unsigned                seen_cnt;
  int unsigned                given_cnt;

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endfunction

  // sum / cnt rounded to nearest, ties away from zero, kept to sample width
  function automatic logic [SAMPLE_W-1:0] rounded_mean(longint total, int unsigned cnt);
    longint unsigned mag;
    longint unsigned q;
    if (total < 0) mag = -total;
    else mag = total;
    q = (mag + cnt / 2) / cnt;
    if (total < 0) return SAMPLE_W'(-longint'(q));
    return SAMPLE_W'(q);
  endfunction

  // average for the sample d places behind the newest one, window shrunk
  //   by how many results this sequence has given so far and by d itself
  function automatic avg_res_t window_mean(int unsigned newest, int unsigned d,
                                           int unsigned h, logic fin);
    int unsigned j;
    int unsigned slot;
    longint sx;
    longint sy;
    longint sz;
    avg_res_t r;
    j = h;
    if (given_cnt < j) j = given_cnt;
    if (d < j) j = d;
    sx = 0;
    sy = 0;
    sz = 0;
    for (int unsigned off = d - j; off <= d + j; off++) begin
      slot = (newest + WIN_DEPTH - off % WIN_DEPTH) % WIN_DEPTH;
      sx += win[slot][0];
      sy += win[slot][1];
      sz += win[slot][2];
    end
    r.x = rounded_mean(sx, 2 * j + 1);
    r.y = rounded_mean(sy, 2 * j + 1);
    r.z = rounded_mean(sz, 2 * j + 1);
    r.fin = fin;
    if (given_cnt < CNT_SAT) given_cnt++;
    return r;
  endfunction

  // one accepted sample: store it, then queue whatever averages it releases
  function automatic void absorb_sample(logic signed [SAMPLE_W-1:0] x,
                                        logic signed [SAMPLE_W-1:0] y,
                                        logic signed [SAMPLE_W-1:0] z, logic last);
    int unsigned h;
    int unsigned newest;
    int unsigned pend;
    h = (hw_reg > MAX_HW) ? MAX_HW : hw_reg;
    newest = wr_slot;
    pend = (seen_cnt < h) ? seen_cnt : h;
    win[newest][0] = x;
    win[newest][1] = y;
    win[newest][2] = z;
    wr_slot = (newest + 1) % WIN_DEPTH;
    if (seen_cnt < CNT_SAT) seen_cnt++;
    if (last) begin
      // flush: every owed average, oldest first, the newest sample marked final
      for (int d = pend; d >= 0; d--)
        owed_avgs.insert(owed_avgs.size(), window_mean(newest, d, h, d == 0));
      seen_cnt = 0;
      given_cnt = 0;
    end else if (pend == h) begin
      owed_avgs.insert(owed_avgs.size(), window_mean(newest, h, h, 1'b0));
    end
  endfunction

  function automatic void push_item(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y,
                                    logic [SAMPLE_W-1:0] z, logic last, bit wait_drain);
    samp_req_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.last = last;
    r.wait_drain = wait_drain;
    sample_backlog.insert(sample_backlog.size(), r);
  endfunction

  // component values lean on the extremes and on values near zero
  function automatic logic [SAMPLE_W-1:0] rand_comp();
    case ($urandom_range(7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom_range(16'hffff));
    endcase
  endfunction

  // wait until no request is queued or offered and nothing is owed
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_backlog.size() != 0 || samp_if.valid || owed_avgs.size() != 0);
  endtask

  task automatic write_half_width(logic [HW_BITS-1:0] v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.half_width <= v;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // sample driver: a new request only once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      samp_if.valid <= 1'b0;
    end else if (!samp_if.valid || samp_if.ready) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(sample_backlog[0].wait_drain && (samp_if.valid || !drained))) begin
        next_req = sample_backlog.pop_front();
        samp_if.valid <= 1'b1;
        samp_if.sample_x <= next_req.x;
        samp_if.sample_y <= next_req.y;
        samp_if.sample_z <= next_req.z;
        samp_if.seq_end <= next_req.last;
      end else begin
        samp_if.valid <= 1'b0;
      end
    end
  end

  // drain state sampled away from the active edge
  always @(negedge clk) drained = (owed_avgs.size() == 0);

  // result receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      avg_if.ready <= 1'b0;
      stall_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      stall_left <= HOLD_CYCLES;
      avg_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      avg_if.ready <= 1'b0;
    end else begin
      avg_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: track config and samples in the shadow, check each average taken
  always @(posedge clk) begin
    if (rst) begin
      hw_reg = HW_RESET;
      wr_slot = 0;
      seen_cnt = 0;
      given_cnt = 0;
    end else begin
      // writes while a sequence is open are dropped by the block
      if (cfg_if.valid && cfg_if.ready && seen_cnt == 0) hw_reg = cfg_if.half_width;
      if (samp_if.valid && samp_if.ready)
        absorb_sample(samp_if.sample_x, samp_if.sample_y, samp_if.sample_z,
                      samp_if.seq_end);
      if (avg_if.valid && avg_if.ready) begin
        if (owed_avgs.size() == 0) begin
          flag_mismatch($sformatf("unexpected average x=%0d y=%0d z=%0d final=%0b",
                                  avg_if.avg_x, avg_if.avg_y, avg_if.avg_z,
                                  avg_if.final_out));
        end else begin
          want_avg = owed_avgs.pop_front();
          if (avg_if.avg_x !== want_avg.x || avg_if.avg_y !== want_avg.y ||
              avg_if.avg_z !== want_avg.z || avg_if.final_out !== want_avg.fin)
            flag_mismatch($sformatf(
              {"average mismatch: expected x=%0d y=%0d z=%0d final=%0b, ",
               "got x=%0d y=%0d z=%0d final=%0b"},
              want_avg.x, want_avg.y, want_avg.z, want_avg.fin,
              avg_if.avg_x, avg_if.avg_y, avg_if.avg_z, avg_if.final_out));
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((samp_if.valid && samp_if.ready) || (avg_if.valid && avg_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int hw_now;
    int count;
    int len;
    rst = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.half_width = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default half width 7, sequence of 10 at the extremes
    for (int i = 0; i < 10; i++) begin
      if (i < 5) push_item(16'h7fff, 16'h8000, 16'h0000, 1'b0, 1'b0);
      else push_item(16'h8000, 16'h7fff, 16'hffff, i == 9, 1'b0);
    end

    // zero half width: each sample is its own average
    wait_idle();
    repeat (LATENCY_PAD) @(posedge clk);
    write_half_width(4'd0);
    @(negedge clk);
    push_item(16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
    push_item(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0);
    push_item(16'hffff, 16'h0000, 16'h0001, 1'b1, 1'b0);

    // widest window with sequences shorter than it: all out on the flush,
    //   including a sequence of a single sample
    wait_idle();
    repeat (LATENCY_PAD) @(posedge clk);
    write_half_width(4'd15);
    @(negedge clk);
    for (int i = 0; i < 5; i++) push_item(rand_comp(), rand_comp(), rand_comp(), i == 4, 1'b0);
    push_item(16'h3039, 16'hcfc7, 16'h0007, 1'b1, 1'b0);

    // write while a sequence is open: must leave the half width at 15
    wait_idle();
    @(negedge clk);
    push_item(rand_comp(), rand_comp(), rand_comp(), 1'b0, 1'b0);
    push_item(rand_comp(), rand_comp(), rand_comp(), 1'b0, 1'b0);
    wait_idle();
    repeat (LATENCY_PAD) @(posedge clk);
    write_half_width(4'd4);
    @(negedge clk);
    for (int i = 0; i < 3; i++) push_item(rand_comp(), rand_comp(), rand_comp(), i == 2, 1'b0);

    // random phases, each with its own half width and idling pattern
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      repeat (LATENCY_PAD) @(posedge clk);
      hw_now = (PHASE_HW[phase] == RANDOM_HW) ? $urandom_range(14, 2) : PHASE_HW[phase];
      write_half_width(HW_BITS'(hw_now));
      @(negedge clk);
      send_idle_pct = SEND_IDLE[phase % 4];
      recv_stall_pct = RECV_STALL[phase % 4];
      // long receiver hold-off while samples keep coming, so the block backs up
      if (phase == 0) hold_reqs++;
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        // mostly sequences around the window size, now and then one that
        //   runs the sequence counters into saturation
        len = ($urandom_range(9) == 0) ? $urandom_range(70, 64)
                                       : $urandom_range(2 * hw_now + 4, 1);
        for (int i = 0; i < len; i++) begin
          // one sender pause until every owed average is in
          push_item(rand_comp(), rand_comp(), rand_comp(), i == len - 1,
                    phase == 1 && count == 20);
          count++;
        end
      end
    end

    wait_idle();
    repeat (LATENCY_PAD) @(posedge clk);
    if (owed_avgs.size() != 0)
      flag_mismatch($sformatf("%0d averages never arrived", owed_avgs.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== centered_moving_average_vec3_core.f =====
rtl/core/cma_pkg.sv
rtl/core/cma_ifs.sv
rtl/core/cma_cell.sv
rtl/core/cma_div.sv
rtl/core/centered_moving_average_vec3_core.sv
tb/sv/tb_centered_moving_average_vec3_core.sv
